[rtl/core/bqf_pkg.sv]
// shared types, widths and constants of the multichannel biquad filter
package bqf_pkg;

    // field widths
    localparam int SAMPLE_W  = 24;
    localparam int CHANNEL_W = 1;
    localparam int COEF_W    = 32;
    localparam int CFG_IDX_W = 3;

    // arithmetic widths: exact products, five-term sum, rounded quotient
    localparam int FRAC_BITS = 28;
    localparam int PROD_W    = SAMPLE_W + COEF_W;
    localparam int ACC_W     = PROD_W + 3;
    localparam int QUOT_W    = ACC_W - FRAC_BITS;

    // saturation limits of a Q1.23 sample
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

    // coefficient values after reset (b0 = 1.0 in Q3.28)
    localparam logic signed [COEF_W-1:0] COEF_B0_RESET = 32'sh1000_0000;
    localparam logic signed [COEF_W-1:0] COEF_ZERO     = 32'sh0000_0000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_B0 = 3'd0,
        REG_COEF_B1 = 3'd1,
        REG_COEF_B2 = 3'd2,
        REG_COEF_A1 = 3'd3,
        REG_COEF_A2 = 3'd4,
        REG_BYPASS  = 3'd5
    } cfg_reg_t;

    // current coefficient set and mode
    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
        logic                     bypass;
    } coef_set_t;

    // history of one channel
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] x1;
        logic signed [SAMPLE_W-1:0] x2;
        logic signed [SAMPLE_W-1:0] y1;
        logic signed [SAMPLE_W-1:0] y2;
    } hist_tap_t;

    // history update request
    typedef struct packed {
        logic                       en;
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
    } hist_upd_t;

endpackage

[rtl/core/multichannel_biquad_filter.sv]
// top level of the multichannel direct form I biquad filter
//
// Accepts one sample beat per clock and returns one result beat per sample,
// in order. A sample is caught in an input register; when the output register
// is free or being read, the filtered result is loaded into the output
// register and that channel's history is shifted, and a new sample can
// enter every cycle unless the output is held (in_ready falls only when
// both registers hold data and out_ready is low). The path between the two
// registers holds five 24x32 multipliers in parallel, one five-term adder,
// rounding and saturation, and it sets the clock limit. Registers (index:
// name): 0 b0, 1 b1, 2 b2, 3 a1, 4 a2 (signed Q3.28, b0 resets to 1.0,
// others to 0) and 5 bypass; writes to other indexes are dropped, and
// registers should be changed only while no sample is in flight. Each of
// CHANNELS channels keeps its own history, cleared by reset; channel numbers
// past the last one use the last channel's history. In bypass the sample
// passes unchanged, clipped stays low and no history moves.
module multichannel_biquad_filter #(
    parameter int CHANNELS = 2
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [bqf_pkg::SAMPLE_W-1:0]   sample_in,
    input  logic [bqf_pkg::CHANNEL_W-1:0]         channel,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [bqf_pkg::SAMPLE_W-1:0]   sample_out,
    output logic [bqf_pkg::CHANNEL_W-1:0]         channel_out,
    output logic                                  clipped,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bqf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [bqf_pkg::COEF_W-1:0]            cfg_data
);
    import bqf_pkg::*;

    coef_set_t                  coef;
    hist_tap_t                  taps;
    hist_upd_t                  upd;

    logic                       stage_valid_reg;
    logic                       stage_valid_next;
    logic signed [SAMPLE_W-1:0] stage_sample_reg;
    logic [CHANNEL_W-1:0]       stage_channel_reg;
    logic                       stage_fire;
    logic                       in_fire;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic [CHANNEL_W-1:0]       out_channel_reg;
    logic                       out_clipped_reg;

    logic signed [SAMPLE_W-1:0] mac_result;
    logic                       mac_clip;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    bqf_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .coef     (coef)
    );

    bqf_history #(
        .CHANNELS (CHANNELS)
    ) u_history (
        .clk     (clk),
        .rst_n   (rst_n),
        .channel (stage_channel_reg),
        .upd     (upd),
        .taps    (taps)
    );

    bqf_mac u_mac (
        .sample (stage_sample_reg),
        .taps   (taps),
        .coef   (coef),
        .result (mac_result),
        .clip   (mac_clip)
    );

    // handshake and stage advance
    always_comb
    begin
        stage_fire       = stage_valid_reg && (!out_valid_reg || out_ready);
        in_ready         = !stage_valid_reg || stage_fire;
        in_fire          = in_valid && in_ready;
        stage_valid_next = in_fire ? 1'b1 : (stage_fire ? 1'b0 : stage_valid_reg);
        out_valid_next   = stage_fire ? 1'b1 :
                           ((out_valid_reg && out_ready) ? 1'b0 : out_valid_reg);
    end

    // history moves only when a filtered result is produced
    always_comb
    begin
        upd.en = stage_fire && !coef.bypass;
        upd.x  = stage_sample_reg;
        upd.y  = mac_result;
    end

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stage_sample_reg  <= sample_in;
            stage_channel_reg <= channel;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (stage_fire)
        begin
            out_sample_reg  <= mac_result;
            out_channel_reg <= stage_channel_reg;
            out_clipped_reg <= mac_clip;
        end
    end

    assign out_valid   = out_valid_reg;
    assign sample_out  = out_sample_reg;
    assign channel_out = out_channel_reg;
    assign clipped     = out_clipped_reg;

`ifndef ASSERT_OFF
    // a clipped result sits on one of the two limits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_clipped_reg |->
            (out_sample_reg == SAMPLE_MAX || out_sample_reg == SAMPLE_MIN))
    else $error("clipped result not at a saturation limit");

    // input stalls only when both registers are full and the output is held
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> stage_valid_reg && out_valid_reg && !out_ready)
    else $error("input stalled with room in the pipeline");

    // a stage advance always leaves a result waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        stage_fire |=> out_valid_reg)
    else $error("result lost after stage advance");
`endif

endmodule

[rtl/core/bqf_cfg_regs.sv]
// coefficient and bypass register file of the biquad filter
module bqf_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [bqf_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [bqf_pkg::COEF_W-1:0]      wr_data,
    output bqf_pkg::coef_set_t              coef
);
    import bqf_pkg::*;

    logic signed [COEF_W-1:0] b0_reg;
    logic signed [COEF_W-1:0] b1_reg;
    logic signed [COEF_W-1:0] b2_reg;
    logic signed [COEF_W-1:0] a1_reg;
    logic signed [COEF_W-1:0] a2_reg;
    logic                     bypass_reg;

    // register writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg     <= COEF_B0_RESET;
            b1_reg     <= COEF_ZERO;
            b2_reg     <= COEF_ZERO;
            a1_reg     <= COEF_ZERO;
            a2_reg     <= COEF_ZERO;
            bypass_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            case (cfg_reg_t'(wr_index))
                REG_COEF_B0: b0_reg     <= signed'(wr_data);
                REG_COEF_B1: b1_reg     <= signed'(wr_data);
                REG_COEF_B2: b2_reg     <= signed'(wr_data);
                REG_COEF_A1: a1_reg     <= signed'(wr_data);
                REG_COEF_A2: a2_reg     <= signed'(wr_data);
                REG_BYPASS:  bypass_reg <= wr_data[0];
                default:     ;
            endcase
        end
    end

    // pack into the coefficient set
    always_comb
    begin
        coef.b0     = b0_reg;
        coef.b1     = b1_reg;
        coef.b2     = b2_reg;
        coef.a1     = a1_reg;
        coef.a2     = a2_reg;
        coef.bypass = bypass_reg;
    end

endmodule

[rtl/core/bqf_history.sv]
// per-channel delay line of past inputs and outputs
module bqf_history #(
    parameter int CHANNELS = 2
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [bqf_pkg::CHANNEL_W-1:0]     channel,
    input  bqf_pkg::hist_upd_t                upd,
    output bqf_pkg::hist_tap_t                taps
);
    import bqf_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [31:0]                ch_wide;
    logic [CH_W-1:0]            idx;
    logic signed [SAMPLE_W-1:0] x1_reg [CHANNELS];
    logic signed [SAMPLE_W-1:0] x2_reg [CHANNELS];
    logic signed [SAMPLE_W-1:0] y1_reg [CHANNELS];
    logic signed [SAMPLE_W-1:0] y2_reg [CHANNELS];

    // out-of-range channels share the last channel's history
    always_comb
    begin
        ch_wide = 32'(channel);
        if (ch_wide >= 32'(CHANNELS))
            idx = CH_W'(CHANNELS - 1);
        else
            idx = CH_W'(ch_wide);
    end

    // read the selected channel
    always_comb
    begin
        taps.x1 = x1_reg[idx];
        taps.x2 = x2_reg[idx];
        taps.y1 = y1_reg[idx];
        taps.y2 = y2_reg[idx];
    end

    // shift the selected channel's delay line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                x1_reg[c] <= '0;
                x2_reg[c] <= '0;
                y1_reg[c] <= '0;
                y2_reg[c] <= '0;
            end
        end
        else if (upd.en)
        begin
            x2_reg[idx] <= x1_reg[idx];
            x1_reg[idx] <= upd.x;
            y2_reg[idx] <= y1_reg[idx];
            y1_reg[idx] <= upd.y;
        end
    end

endmodule

[rtl/core/bqf_mac.sv]
// five-tap multiply-accumulate with rounding and saturation
module bqf_mac (
    input  logic signed [bqf_pkg::SAMPLE_W-1:0]  sample,
    input  bqf_pkg::hist_tap_t                   taps,
    input  bqf_pkg::coef_set_t                   coef,
    output logic signed [bqf_pkg::SAMPLE_W-1:0]  result,
    output logic                                 clip
);
    import bqf_pkg::*;

    localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [QUOT_W-1:0] QUOT_MAX   = QUOT_W'(SAMPLE_MAX);
    localparam logic signed [QUOT_W-1:0] QUOT_MIN   = QUOT_W'(SAMPLE_MIN);

    logic signed [PROD_W-1:0] p_b0;
    logic signed [PROD_W-1:0] p_b1;
    logic signed [PROD_W-1:0] p_b2;
    logic signed [PROD_W-1:0] p_a1;
    logic signed [PROD_W-1:0] p_a2;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  rounded;
    logic signed [QUOT_W-1:0] quot;

    // exact products, five in parallel
    always_comb
    begin
        p_b0 = coef.b0 * sample;
        p_b1 = coef.b1 * taps.x1;
        p_b2 = coef.b2 * taps.x2;
        p_a1 = coef.a1 * taps.y1;
        p_a2 = coef.a2 * taps.y2;
    end

    // exact sum, round half up, floor shift to Q1.23
    always_comb
    begin
        acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
            - ACC_W'(p_a1) - ACC_W'(p_a2);
        rounded = acc + ROUND_HALF;
        quot    = signed'(rounded[ACC_W-1:FRAC_BITS]);
    end

    // saturate, or pass straight through in bypass
    always_comb
    begin
        if (coef.bypass)
        begin
            result = sample;
            clip   = 1'b0;
        end
        else if (quot > QUOT_MAX)
        begin
            result = SAMPLE_MAX;
            clip   = 1'b1;
        end
        else if (quot < QUOT_MIN)
        begin
            result = SAMPLE_MIN;
            clip   = 1'b1;
        end
        else
        begin
            result = quot[SAMPLE_W-1:0];
            clip   = 1'b0;
        end
    end

endmodule

[test/tb_multichannel_biquad_filter.sv]
// self-checking testbench for the multichannel direct form I biquad filter
`timescale 1ns / 1ps

module tb_multichannel_biquad_filter;

    import bqf_pkg::*;

    localparam int CHANNELS      = 2;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 8;
    localparam int STALL_LIMIT   = 4000;
    localparam int EPOCHS        = 4;
    localparam int EPOCH_ITEMS   = 150;

    // well-behaved low-pass style coefficient set, Q3.28
    localparam logic [COEF_W-1:0] STABLE_B0 = 32'sh0400_0000;
    localparam logic [COEF_W-1:0] STABLE_B1 = 32'sh0800_0000;
    localparam logic [COEF_W-1:0] STABLE_B2 = 32'sh0400_0000;
    localparam logic [COEF_W-1:0] STABLE_A1 = 32'shF800_0000;
    localparam logic [COEF_W-1:0] STABLE_A2 = 32'sh0200_0000;

    // register indexes past the end of the register list
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_BYPASS + 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = REG_BYPASS + 3'd2;

    typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_e;
    typedef enum int {COEF_STABLE, COEF_FULL, COEF_MODERATE} coef_flavour_e;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] y;
        logic [CHANNEL_W-1:0]       ch;
        logic                       clip;
    } result_beat_t;

    typedef struct packed {
        row_kind_e                  kind;
        logic [CFG_IDX_W-1:0]       idx;
        logic [COEF_W-1:0]          data;
        logic signed [SAMPLE_W-1:0] x;
        logic [CHANNEL_W-1:0]       ch;
        logic                       known;
        logic signed [SAMPLE_W-1:0] y;
        logic                       clip;
    } dir_row_t;

    // block ports
    logic                         clk         = 1'b0;
    logic                         rst_n       = 1'b0;
    logic                         in_valid    = 1'b0;
    logic                         in_ready;
    logic signed [SAMPLE_W-1:0]   sample_in   = '0;
    logic [CHANNEL_W-1:0]         channel     = '0;
    logic                         out_valid;
    logic                         out_ready   = 1'b0;
    logic signed [SAMPLE_W-1:0]   sample_out;
    logic [CHANNEL_W-1:0]         channel_out;
    logic                         clipped;
    logic                         cfg_valid   = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index   = '0;
    logic [COEF_W-1:0]            cfg_data    = '0;

    // filter mirror: coefficients, mode and per-channel history
    coef_set_t    coefs;
    hist_tap_t    chan_hist [CHANNELS];
    result_beat_t pending_results [$];

    int send_idle_pct = 16;
    int recv_idle_pct = 69;
    int stall_cycles  = 0;
    int mismatches    = 0;
    int samples_sent  = 0;
    int bypass_beats  = 0;
    int results_checked = 0;
    int clipped_seen  = 0;
    int coef_settings = 0;

    multichannel_biquad_filter #(
        .CHANNELS(CHANNELS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .sample_in(sample_in),
        .channel(channel),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .sample_out(sample_out),
        .channel_out(channel_out),
        .clipped(clipped),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // biquad step: exact products, round half up, saturate, shift history
    function automatic result_beat_t biquad_step(input logic signed [SAMPLE_W-1:0] x,
                                                 input logic [CHANNEL_W-1:0] ch);
        int unsigned  c;
        longint       acc;
        longint       q;
        result_beat_t r;
        c = (ch >= CHANNELS) ? CHANNELS - 1 : ch;
        r.ch = ch;
        r.clip = 1'b0;
        if (coefs.bypass)
        begin
            r.y = x;
            return r;
        end
        acc = longint'(coefs.b0) * longint'(x)
            + longint'(coefs.b1) * longint'(chan_hist[c].x1)
            + longint'(coefs.b2) * longint'(chan_hist[c].x2)
            - longint'(coefs.a1) * longint'(chan_hist[c].y1)
            - longint'(coefs.a2) * longint'(chan_hist[c].y2);
        q = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (q > longint'(SAMPLE_MAX))
        begin
            q = longint'(SAMPLE_MAX);
            r.clip = 1'b1;
        end
        else if (q < longint'(SAMPLE_MIN))
        begin
            q = longint'(SAMPLE_MIN);
            r.clip = 1'b1;
        end
        r.y = q[SAMPLE_W-1:0];
        chan_hist[c].x2 = chan_hist[c].x1;
        chan_hist[c].x1 = x;
        chan_hist[c].y2 = chan_hist[c].y1;
        chan_hist[c].y1 = r.y;
        return r;
    endfunction

    // coefficient pick for one register of a random setting
    function automatic logic [COEF_W-1:0] pick_coef(input coef_flavour_e flavour,
                                                    input logic [COEF_W-1:0] base);
        case (flavour)
            COEF_STABLE:   return base + int'($urandom_range(2 ** 21)) - 2 ** 20;
            COEF_FULL:     return $urandom;
            default:       return int'($urandom_range(2 ** 30 - 1)) - 2 ** 29;
        endcase
    endfunction

    // directed table rows
    function automatic dir_row_t sample_row(input logic signed [SAMPLE_W-1:0] x,
                                            input logic [CHANNEL_W-1:0] ch);
        dir_row_t r;
        r = '0;
        r.kind = ROW_SAMPLE;
        r.x = x;
        r.ch = ch;
        return r;
    endfunction

    function automatic dir_row_t known_row(input logic signed [SAMPLE_W-1:0] x,
                                           input logic [CHANNEL_W-1:0] ch,
                                           input logic signed [SAMPLE_W-1:0] y,
                                           input logic clip);
        dir_row_t r;
        r = sample_row(x, ch);
        r.known = 1'b1;
        r.y = y;
        r.clip = clip;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [COEF_W-1:0] data);
        dir_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s, got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // one sample beat, with a random gap in front
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x,
                               input logic [CHANNEL_W-1:0] ch,
                               input logic known,
                               input logic signed [SAMPLE_W-1:0] want_y,
                               input logic want_clip);
        result_beat_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid  <= 1'b0;
            sample_in <= SAMPLE_W'($urandom);
            channel   <= CHANNEL_W'($urandom);
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        sample_in <= x;
        channel   <= ch;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (coefs.bypass)
            bypass_beats++;
        predicted = biquad_step(x, ch);
        if (known)
            pending_results.push_back('{y: want_y, ch: ch, clip: want_clip});
        else
            pending_results.push_back(predicted);
        samples_sent++;
    endtask

    // hold off until every pending result is out and the pipeline is empty
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // register write beat, mirrored on acceptance
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_COEF_B0: coefs.b0 = data;
            REG_COEF_B1: coefs.b1 = data;
            REG_COEF_B2: coefs.b2 = data;
            REG_COEF_A1: coefs.a1 = data;
            REG_COEF_A2: coefs.a2 = data;
            REG_BYPASS:  coefs.bypass = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // receiver stalls
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // result beat check and handshake activity
    always @(posedge clk)
    begin : result_check
        result_beat_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result beat with nothing pending", sample_out, 0);
                else
                begin
                    want = pending_results.pop_front();
                    if (sample_out !== want.y)
                        report_mismatch("sample_out", sample_out, want.y);
                    if (channel_out !== want.ch)
                        report_mismatch("channel_out", channel_out, want.ch);
                    if (clipped !== want.clip)
                        report_mismatch("clipped", clipped, want.clip);
                    if (want.clip)
                        clipped_seen++;
                end
                results_checked++;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // watchdog on handshake activity
    initial
    begin
        wait (rst_n === 1'b1);
        while (stall_cycles < STALL_LIMIT)
            @(negedge clk);
        $display("TB_ERROR");
        $finish;
    end

    // stimulus
    initial
    begin
        dir_row_t      dir_table [$];
        dir_row_t      row;
        coef_flavour_e flavour;
        logic [COEF_W-1:0] mode_word;
        logic signed [SAMPLE_W-1:0] x;
        int            send_idle_by_phase [3];
        int            recv_idle_by_phase [3];

        send_idle_by_phase = '{16, 69, 0};
        recv_idle_by_phase = '{69, 16, 0};

        coefs.b0 = COEF_B0_RESET;
        coefs.b1 = COEF_ZERO;
        coefs.b2 = COEF_ZERO;
        coefs.a1 = COEF_ZERO;
        coefs.a2 = COEF_ZERO;
        coefs.bypass = 1'b0;
        for (int c = 0; c < CHANNELS; c++)
            chan_hist[c] = '0;

        // unity gain after reset
        dir_table.push_back(known_row(SAMPLE_MAX, 1'b0, SAMPLE_MAX, 1'b0));
        dir_table.push_back(known_row(SAMPLE_MIN, 1'b1, SAMPLE_MIN, 1'b0));
        dir_table.push_back(known_row('0, 1'b0, '0, 1'b0));
        dir_table.push_back(known_row(-24'sd1, 1'b1, -24'sd1, 1'b0));
        // largest positive gain saturates both ways
        dir_table.push_back(cfg_row(REG_COEF_B0, 32'h7FFF_FFFF));
        dir_table.push_back(known_row(SAMPLE_MAX, 1'b0, SAMPLE_MAX, 1'b1));
        dir_table.push_back(known_row(SAMPLE_MIN, 1'b1, SAMPLE_MIN, 1'b1));
        // gain one half: exact halves round towards plus infinity
        dir_table.push_back(cfg_row(REG_COEF_B0, 32'h0800_0000));
        dir_table.push_back(known_row(24'sd1, 1'b0, 24'sd1, 1'b0));
        dir_table.push_back(known_row(-24'sd1, 1'b1, '0, 1'b0));
        dir_table.push_back(known_row(24'sd3, 1'b0, 24'sd2, 1'b0));
        dir_table.push_back(known_row(-24'sd3, 1'b1, -24'sd1, 1'b0));
        // most negative gain
        dir_table.push_back(cfg_row(REG_COEF_B0, 32'h8000_0000));
        dir_table.push_back(known_row(SAMPLE_MIN, 1'b0, SAMPLE_MAX, 1'b1));
        dir_table.push_back(known_row(24'sd1, 1'b1, -24'sd8, 1'b0));
        // history taps at their extremes
        dir_table.push_back(cfg_row(REG_COEF_B1, 32'h7FFF_FFFF));
        dir_table.push_back(cfg_row(REG_COEF_B2, 32'h8000_0000));
        dir_table.push_back(cfg_row(REG_COEF_A1, 32'h8000_0000));
        dir_table.push_back(cfg_row(REG_COEF_A2, 32'h7FFF_FFFF));
        dir_table.push_back(sample_row(24'sh123456, 1'b0));
        dir_table.push_back(sample_row(-24'sh002345, 1'b1));
        dir_table.push_back(sample_row(SAMPLE_MAX, 1'b0));
        // bypass passes samples and leaves history alone
        dir_table.push_back(cfg_row(REG_BYPASS, 32'hFFFF_FFFF));
        dir_table.push_back(known_row(24'sh5A5A5A, 1'b0, 24'sh5A5A5A, 1'b0));
        dir_table.push_back(known_row(SAMPLE_MIN, 1'b1, SAMPLE_MIN, 1'b0));
        // writes past the register list are dropped
        dir_table.push_back(cfg_row(REG_SPARE_LO, 32'hFFFF_FFFF));
        dir_table.push_back(cfg_row(REG_SPARE_HI, 32'h0000_0001));
        dir_table.push_back(cfg_row(REG_BYPASS, 32'hFFFF_FFFE));
        dir_table.push_back(sample_row(24'sd7, 1'b0));
        dir_table.push_back(sample_row(-24'sd7, 1'b1));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed walk
        foreach (dir_table[i])
        begin
            row = dir_table[i];
            if (row.kind == ROW_CFG)
            begin
                wait_drained();
                write_register(row.idx, row.data);
                coef_settings++;
            end
            else
                send_sample(row.x, row.ch, row.known, row.y, row.clip);
        end

        // random settings under three idling patterns
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = send_idle_by_phase[phase];
            recv_idle_pct = recv_idle_by_phase[phase];
            for (int epoch = 0; epoch < EPOCHS; epoch++)
            begin
                wait_drained();
                flavour = coef_flavour_e'($urandom_range(2));
                write_register(REG_COEF_B0, pick_coef(flavour, STABLE_B0));
                write_register(REG_COEF_B1, pick_coef(flavour, STABLE_B1));
                write_register(REG_COEF_B2, pick_coef(flavour, STABLE_B2));
                write_register(REG_COEF_A1, pick_coef(flavour, STABLE_A1));
                write_register(REG_COEF_A2, pick_coef(flavour, STABLE_A2));
                mode_word = $urandom;
                mode_word[0] = ($urandom_range(4) == 0);
                write_register(REG_BYPASS, mode_word);
                coef_settings++;
                for (int n = 0; n < EPOCH_ITEMS; n++)
                begin
                    // occasional full pause until the output side catches up
                    if ($urandom_range(149) == 0)
                        wait_drained();
                    case ($urandom_range(19))
                        0, 1, 2:
                            x = SAMPLE_W'(int'($urandom_range(512)) - 256);
                        3, 4, 5:
                            case ($urandom_range(3))
                                0:       x = SAMPLE_MAX;
                                1:       x = SAMPLE_MIN;
                                2:       x = '0;
                                default: x = -24'sd1;
                            endcase
                        default:
                            x = SAMPLE_W'($urandom);
                    endcase
                    send_sample(x, CHANNEL_W'($urandom), 1'b0, '0, 1'b0);
                end
            end
        end

        wait_drained();
        repeat (END_CYCLES) @(negedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 0, pending_results.size());

        $display("sent %0d sample beats, %0d in bypass, over %0d coefficient settings",
                 samples_sent, bypass_beats, coef_settings);
        $display("checked %0d result beats, %0d saturated, across three stall patterns",
                 results_checked, clipped_seen);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
